[design/tpasc_pkg.sv]
// ----------------------------------------------------------------------------
// tpasc_pkg: shared definitions for the TRIAC phase-angle speed control.
// Field widths, register map, reset values and the level lamp decode.
// ----------------------------------------------------------------------------
package tpasc_pkg;

  localparam int unsigned TimeW    = 16;
  localparam int unsigned StepW    = 10;
  localparam int unsigned LevelW   = 3;
  localparam int unsigned LampW    = 6;
  localparam int unsigned LevelCnt = 6;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = 5;

  localparam logic [LevelW-1:0] LevelMax   = 3'd5;
  localparam logic [TimeW-1:0]  ElapsedMax = 16'hFFFF;

  localparam logic [TimeW-1:0] DelayRst0    = 16'd20000;
  localparam logic [TimeW-1:0] DelayRst1    = 16'd6660;
  localparam logic [TimeW-1:0] DelayRst2    = 16'd5410;
  localparam logic [TimeW-1:0] DelayRst3    = 16'd4580;
  localparam logic [TimeW-1:0] DelayRst4    = 16'd4160;
  localparam logic [TimeW-1:0] DelayRst5    = 16'd0;
  localparam logic [StepW-1:0] TickStepRst  = 10'd100;
  localparam logic [TimeW-1:0] GateWinRst   = 16'd300;
  localparam logic [TimeW-1:0] FireDelayRst = 16'd8330;

  typedef enum logic [2:0] {
    RegDelay0     = 3'd0,
    RegDelay1     = 3'd1,
    RegDelay2     = 3'd2,
    RegDelay3     = 3'd3,
    RegDelay4     = 3'd4,
    RegDelay5     = 3'd5,
    RegTickStep   = 3'd6,
    RegGateWindow = 3'd7
  } reg_idx_e;

  typedef logic [TimeW-1:0] time_t;

  function automatic logic [LampW-1:0] lamp_decode(input logic [LevelW-1:0] lvl);
    logic [LampW-1:0] lamp;
    case (lvl)
      3'd1:    lamp = 6'b000001;
      3'd2:    lamp = 6'b000010;
      3'd3:    lamp = 6'b000100;
      3'd4:    lamp = 6'b001000;
      3'd5:    lamp = 6'b100000;
      default: lamp = 6'b000000;
    endcase
    return lamp;
  endfunction

endpackage

[design/tpasc_in_if.sv]
// ----------------------------------------------------------------------------
// tpasc_in_if: input word channel of the speed control.
// Carries the tick, zero-cross and button samples with valid and ready.
// ----------------------------------------------------------------------------
interface tpasc_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic zero_cross;
  logic up_button;
  logic down_button;

  modport source (output valid, output tick, output zero_cross, output up_button,
                  output down_button, input ready);
  modport sink (input valid, input tick, input zero_cross, input up_button,
                input down_button, output ready);
endinterface

[design/tpasc_out_if.sv]
// ----------------------------------------------------------------------------
// tpasc_out_if: result word channel of the speed control.
// Carries the gate drive, speed level and lamp pattern with valid and ready.
// ----------------------------------------------------------------------------
interface tpasc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           gate_on;
  logic [tpasc_pkg::LevelW-1:0]   speed_level;
  logic [tpasc_pkg::LampW-1:0]    level_indicator;

  modport source (output valid, output gate_on, output speed_level,
                  output level_indicator, input ready);
  modport sink (input valid, input gate_on, input speed_level,
                input level_indicator, output ready);
endinterface

[design/triac_phase_angle_speed_control_unit.sv]
// ----------------------------------------------------------------------------
// triac_phase_angle_speed_control_unit: open-loop TRIAC phase-angle control.
// A word accepted into the input register is computed and held in the result
// register. Throughput: one word per cycle while results are taken, set by the
// single combinational pass from the input register to the result register.
// Reset: configuration, control state and both valids clear; data regs do not.
// ----------------------------------------------------------------------------
module triac_phase_angle_speed_control_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tpasc_in_if.sink                     in_i,
  tpasc_out_if.source                  out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpasc_pkg::AddrW-1:0]  paddr,
  input  logic [tpasc_pkg::DataW-1:0]  pwdata,
  output logic [tpasc_pkg::DataW-1:0]  prdata,
  output logic                         pready
);
  import tpasc_pkg::*;

  // Configuration registers.
  time_t              delay_q [LevelCnt];
  logic [StepW-1:0]   step_q;
  time_t              window_q;
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  // Input register.
  logic s_valid_q, s_tick_q, s_zc_q, s_up_q, s_down_q;

  // Control state.
  time_t              elapsed_q, elapsed_d;
  time_t              fire_q, fire_d;
  logic [LevelW-1:0]  level_q, level_d;
  logic               up_prev_q, up_prev_d;
  logic               down_prev_q, down_prev_d;
  logic               gate_q, gate_d;

  // Result register.
  logic               o_valid_q;
  logic               o_gate_q;
  logic [LevelW-1:0]  o_level_q;
  logic [LampW-1:0]   o_lamp_q;

  logic               advance;
  logic [TimeW:0]     sum;
  logic [TimeW:0]     window_end;
  time_t              elapsed_tick;
  time_t              new_delay;
  logic               reload;

  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      RegDelay0:     prdata = {{(DataW-TimeW){1'b0}}, delay_q[0]};
      RegDelay1:     prdata = {{(DataW-TimeW){1'b0}}, delay_q[1]};
      RegDelay2:     prdata = {{(DataW-TimeW){1'b0}}, delay_q[2]};
      RegDelay3:     prdata = {{(DataW-TimeW){1'b0}}, delay_q[3]};
      RegDelay4:     prdata = {{(DataW-TimeW){1'b0}}, delay_q[4]};
      RegDelay5:     prdata = {{(DataW-TimeW){1'b0}}, delay_q[5]};
      RegTickStep:   prdata = {{(DataW-StepW){1'b0}}, step_q};
      RegGateWindow: prdata = {{(DataW-TimeW){1'b0}}, window_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q[0] <= DelayRst0;
      delay_q[1] <= DelayRst1;
      delay_q[2] <= DelayRst2;
      delay_q[3] <= DelayRst3;
      delay_q[4] <= DelayRst4;
      delay_q[5] <= DelayRst5;
      step_q     <= TickStepRst;
      window_q   <= GateWinRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegDelay0:     delay_q[0] <= pwdata[TimeW-1:0];
        RegDelay1:     delay_q[1] <= pwdata[TimeW-1:0];
        RegDelay2:     delay_q[2] <= pwdata[TimeW-1:0];
        RegDelay3:     delay_q[3] <= pwdata[TimeW-1:0];
        RegDelay4:     delay_q[4] <= pwdata[TimeW-1:0];
        RegDelay5:     delay_q[5] <= pwdata[TimeW-1:0];
        RegTickStep:   step_q     <= pwdata[StepW-1:0];
        RegGateWindow: window_q   <= pwdata[TimeW-1:0];
        default:       ;
      endcase
    end
  end

  // Handshake: the input register advances whenever the result register is
  // free or being emptied.
  assign advance    = s_valid_q && (!o_valid_q || out_o.ready);
  assign in_i.ready = !s_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s_tick_q <= in_i.tick;
      s_zc_q   <= in_i.zero_cross;
      s_up_q   <= in_i.up_button;
      s_down_q <= in_i.down_button;
    end
  end

  always_comb begin
    new_delay = delay_q[0];
    case (level_d)
      3'd1:    new_delay = delay_q[1];
      3'd2:    new_delay = delay_q[2];
      3'd3:    new_delay = delay_q[3];
      3'd4:    new_delay = delay_q[4];
      3'd5:    new_delay = delay_q[5];
      default: new_delay = delay_q[0];
    endcase
  end

  always_comb begin
    sum          = {1'b0, elapsed_q} + {{(TimeW+1-StepW){1'b0}}, step_q};
    window_end   = {1'b0, fire_q} + {1'b0, window_q};
    elapsed_tick = sum[TimeW] ? ElapsedMax : sum[TimeW-1:0];

    gate_d    = gate_q;
    elapsed_d = elapsed_q;
    if (s_tick_q) begin
      elapsed_d = elapsed_tick;
      gate_d    = (elapsed_tick >= fire_q) && ({1'b0, elapsed_tick} <= window_end);
    end
    if (s_zc_q) begin
      elapsed_d = '0;
    end

    up_prev_d   = up_prev_q;
    down_prev_d = down_prev_q;
    level_d     = level_q;
    reload      = 1'b0;
    if (s_up_q != up_prev_q) begin
      up_prev_d = s_up_q;
      if (!s_up_q && level_q < LevelMax) begin
        level_d = level_q + 3'd1;
        reload  = 1'b1;
      end
    end else if (s_down_q != down_prev_q) begin
      down_prev_d = s_down_q;
      if (!s_down_q && level_q != '0) begin
        level_d = level_q - 3'd1;
        reload  = 1'b1;
      end
    end
    fire_d = reload ? new_delay : fire_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      fire_q      <= FireDelayRst;
      level_q     <= '0;
      up_prev_q   <= 1'b1;
      down_prev_q <= 1'b1;
      gate_q      <= 1'b0;
    end else if (advance) begin
      elapsed_q   <= elapsed_d;
      fire_q      <= fire_d;
      level_q     <= level_d;
      up_prev_q   <= up_prev_d;
      down_prev_q <= down_prev_d;
      gate_q      <= gate_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (advance) begin
      o_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      o_gate_q  <= gate_d;
      o_level_q <= level_d;
      o_lamp_q  <= lamp_decode(level_d);
    end
  end

  assign out_o.valid           = o_valid_q;
  assign out_o.gate_on         = o_gate_q;
  assign out_o.speed_level     = o_level_q;
  assign out_o.level_indicator = o_lamp_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LevelMax)
    else $error("speed level out of range");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_o.valid)
    else $error("processed word did not produce a result");

  a_gate_on_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !s_tick_q) |=> $stable(gate_q))
    else $error("gate changed without a tick");

  a_zero_cross_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s_zc_q) |=> (elapsed_q == '0))
    else $error("zero crossing did not clear elapsed time");

  a_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (level_q == $past(level_q) || level_q == $past(level_q) + 3'd1 ||
                 level_q == $past(level_q) - 3'd1))
    else $error("speed level moved by more than one step");

endmodule

[dv/tpasc_motor_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpasc_motor_checker: result checker for the TRIAC phase-angle speed control.
// Mirrors the register file from the APB writes, predicts the gate, level and
// lamp word for every accepted input word, and compares each accepted result
// word in order. APB reads are checked against the mirrored registers.
// ----------------------------------------------------------------------------
module tpasc_motor_checker
  import tpasc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               tick_i,
  input  logic               zero_cross_i,
  input  logic               up_button_i,
  input  logic               down_button_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               gate_on_i,
  input  logic [LevelW-1:0]  speed_level_i,
  input  logic [LampW-1:0]   level_indicator_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [AddrW-1:0]   paddr_i,
  input  logic [DataW-1:0]   pwdata_i,
  input  logic [DataW-1:0]   prdata_i,
  output int                 mismatches_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 fired_o,
  output int                 saturated_o,
  output logic [LevelCnt-1:0] levels_seen_o
);

  typedef struct packed {
    logic              gate_on;
    logic [LevelW-1:0] level;
    logic [LampW-1:0]  lamps;
  } motor_word_t;

  motor_word_t      motor_words_q[$];
  time_t            delay_tab[LevelCnt];
  logic [StepW-1:0] step_us;
  time_t            window_us;
  time_t            elapsed_us;
  time_t            fire_delay_us;
  logic [LevelW-1:0] level;
  logic             up_prev;
  logic             down_prev;
  logic             gate_state;

  function automatic void flag(input string msg);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic motor_word_t advance_motor(input logic tick, input logic zc,
                                                input logic up, input logic dn);
    logic [TimeW:0] sum;
    logic [TimeW:0] window_end;
    motor_word_t    word;
    if (tick) begin
      sum        = {1'b0, elapsed_us} + {{(TimeW+1-StepW){1'b0}}, step_us};
      window_end = {1'b0, fire_delay_us} + {1'b0, window_us};
      elapsed_us = sum[TimeW] ? ElapsedMax : sum[TimeW-1:0];
      if (sum[TimeW]) begin
        saturated_o++;
      end
      gate_state = ({1'b0, elapsed_us} >= {1'b0, fire_delay_us}) &&
                   ({1'b0, elapsed_us} <= window_end);
    end
    if (zc) begin
      elapsed_us = '0;
    end
    // A down change waits while the up button is changing.
    if (up != up_prev) begin
      up_prev = up;
      if (!up && level < LevelMax) begin
        level         = level + 1'b1;
        fire_delay_us = delay_tab[level];
      end
    end else if (dn != down_prev) begin
      down_prev = dn;
      if (!dn && level != '0) begin
        level         = level - 1'b1;
        fire_delay_us = delay_tab[level];
      end
    end
    word.gate_on = gate_state;
    word.level   = level;
    case (level)
      3'd1:    word.lamps = 6'b000001;
      3'd2:    word.lamps = 6'b000010;
      3'd3:    word.lamps = 6'b000100;
      3'd4:    word.lamps = 6'b001000;
      3'd5:    word.lamps = 6'b100000;
      default: word.lamps = 6'b000000;
    endcase
    return word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    motor_word_t      want;
    motor_word_t      got;
    logic [DataW-1:0] reg_now;
    reg_idx_e         idx;
    if (!rst_ni) begin
      delay_tab     = '{DelayRst0, DelayRst1, DelayRst2, DelayRst3, DelayRst4, DelayRst5};
      step_us       = TickStepRst;
      window_us     = GateWinRst;
      elapsed_us    = '0;
      fire_delay_us = FireDelayRst;
      level         = '0;
      up_prev       = 1'b1;
      down_prev     = 1'b1;
      gate_state    = 1'b0;
      motor_words_q.delete();
      mismatches_o  = 0;
      pending_o     = 0;
      checked_o     = 0;
      fired_o       = 0;
      saturated_o   = 0;
      levels_seen_o = '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{gate_on_i, speed_level_i, level_indicator_i};
        if (motor_words_q.size() == 0) begin
          flag($sformatf("Unexpected result word: gate %0b level %0d lamps %b",
                         got.gate_on, got.level, got.lamps));
        end else begin
          want = motor_words_q.pop_front();
          checked_o++;
          if (got.gate_on) begin
            fired_o++;
          end
          if (got.level < LevelCnt) begin
            levels_seen_o[got.level] = 1'b1;
          end
          if (got !== want) begin
            flag($sformatf({"Result word %0d mismatch: expected gate %0b level %0d ",
                            "lamps %b, got gate %0b level %0d lamps %b"}, checked_o,
                           want.gate_on, want.level, want.lamps,
                           got.gate_on, got.level, got.lamps));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        motor_words_q.push_back(advance_motor(tick_i, zero_cross_i, up_button_i,
                                              down_button_i));
      end
      if (psel_i && penable_i && pready_i) begin
        idx = reg_idx_e'(paddr_i[AddrW-1:2]);
        if (pwrite_i) begin
          case (idx)
            RegTickStep:   step_us = pwdata_i[StepW-1:0];
            RegGateWindow: window_us = pwdata_i[TimeW-1:0];
            default:       delay_tab[idx] = pwdata_i[TimeW-1:0];
          endcase
        end else begin
          case (idx)
            RegTickStep:   reg_now = DataW'(step_us);
            RegGateWindow: reg_now = DataW'(window_us);
            default:       reg_now = DataW'(delay_tab[idx]);
          endcase
          if (prdata_i !== reg_now) begin
            flag($sformatf("Register read %s: expected %0d, got %0d",
                           idx.name(), reg_now, prdata_i));
          end
        end
      end
      pending_o = motor_words_q.size();
    end
  end

endmodule

[dv/tb_triac_phase_angle_speed_control_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triac_phase_angle_speed_control_unit: regression for the speed control.
// Drives a short directed run through every speed level, the gate window
// edges and the button corner cases, then random words under several register
// settings with random idling on both sides and one long result stall. The
// checker module predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_triac_phase_angle_speed_control_unit;
  import tpasc_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  tpasc_in_if  in_if ();
  tpasc_out_if out_if ();

  int                  mismatches;
  int                  pending;
  int                  checked;
  int                  fired;
  int                  saturated;
  logic [LevelCnt-1:0] levels_seen;

  int   words_sent = 0;
  int   settings_used = 0;
  int   drain_failures = 0;
  int   results_taken = 0;
  int   zc_countdown = 50;
  bit   hold_done = 1'b0;
  logic up_level = 1'b1;
  logic down_level = 1'b1;

  always #1 clk_i = ~clk_i;

  triac_phase_angle_speed_control_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tpasc_motor_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_if.valid),
    .in_ready_i        (in_if.ready),
    .tick_i            (in_if.tick),
    .zero_cross_i      (in_if.zero_cross),
    .up_button_i       (in_if.up_button),
    .down_button_i     (in_if.down_button),
    .out_valid_i       (out_if.valid),
    .out_ready_i       (out_if.ready),
    .gate_on_i         (out_if.gate_on),
    .speed_level_i     (out_if.speed_level),
    .level_indicator_i (out_if.level_indicator),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .prdata_i          (prdata),
    .mismatches_o      (mismatches),
    .pending_o         (pending),
    .checked_o         (checked),
    .fired_o           (fired),
    .saturated_o       (saturated),
    .levels_seen_o     (levels_seen)
  );

  initial begin
    #200us;
    $display("[FAIL] regression broken");
    $finish;
  end

  // The result side stalls at random, except for one quiet stretch, and holds
  // off once for a long run so that the block backs up into its input.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        results_taken++;
      end
      if (!hold_done && results_taken >= 300) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (results_taken >= 700 && results_taken < 900) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 6);
      end
    end
  end

  task automatic send_word(input logic tick, input logic zc, input logic up,
                           input logic dn);
    while (!(words_sent >= 600 && words_sent < 800) && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.tick        <= tick;
    in_if.zero_cross  <= zc;
    in_if.up_button   <= up;
    in_if.down_button <= dn;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    words_sent++;
  endtask

  task automatic apb_access(input logic write_en, input reg_idx_e idx,
                            input logic [DataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk_i);
    while (pending != 0 && guard < 1000) begin
      @(negedge clk_i);
      guard++;
    end
    if (pending != 0) begin
      drain_failures++;
    end
    repeat (3) @(negedge clk_i);
  endtask

  task automatic load_setting(input int phase);
    time_t            delays[LevelCnt];
    logic [StepW-1:0] step;
    time_t            window;
    case (phase)
      0: begin
        delays = '{16'd0, 16'd1000, 16'd2000, 16'd3000, 16'd4000, 16'd5000};
        step   = 10'd1000;
        window = 16'hFFFF;
      end
      1: begin
        delays = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        step   = 10'd1000;
        window = 16'd0;
      end
      2: begin
        delays = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        step   = 10'd1;
        window = 16'd150;
      end
      default: begin
        for (int i = 0; i < LevelCnt; i++) begin
          delays[i] = time_t'($urandom_range(phase == 5 ? 65535 : 20000, 0));
        end
        step   = StepW'($urandom_range(1000, 1));
        window = time_t'($urandom_range(phase == 5 ? 65535 : 2000, 0));
      end
    endcase
    for (int i = 0; i < LevelCnt; i++) begin
      apb_access(1'b1, reg_idx_e'(i), DataW'(delays[i]));
    end
    apb_access(1'b1, RegTickStep, DataW'(step));
    apb_access(1'b1, RegGateWindow, DataW'(window));
    for (int i = 0; i <= RegGateWindow; i++) begin
      apb_access(1'b0, reg_idx_e'(i), '0);
    end
    settings_used++;
  endtask

  // Mostly mains-like traffic: ticks with a zero crossing every so many ticks
  // and clean press and release edges; the rest is random noise.
  task automatic run_traffic(input int count);
    logic tick;
    logic zc;
    int   pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 90) begin
        tick = ($urandom_range(3) != 0);
        if (tick) begin
          zc_countdown--;
        end
        zc = (zc_countdown <= 0) || ($urandom_range(99) == 0);
        if (zc) begin
          zc_countdown = $urandom_range(120, 20);
        end
        pick = $urandom_range(15);
        if (pick == 0 || pick == 2) begin
          up_level = ~up_level;
        end
        if (pick == 1 || pick == 2) begin
          down_level = ~down_level;
        end
      end else begin
        tick       = 1'($urandom_range(1));
        zc         = 1'($urandom_range(1));
        up_level   = 1'($urandom_range(1));
        down_level = 1'($urandom_range(1));
      end
      send_word(tick, zc, up_level, down_level);
    end
  endtask

  initial begin : stimulus
    logic [3:0] opening[25];
    // Each word is {tick, zero_cross, up_button, down_button}. The run climbs
    // to full speed, presses up at the top, walks the gate across its window
    // edges, clears the time on a crossing, and then changes both buttons.
    opening = '{4'b0011, 4'b1011, 4'b0001, 4'b0011, 4'b0001, 4'b0011, 4'b0001,
                4'b0011, 4'b0001, 4'b0011, 4'b0001, 4'b0011, 4'b0001, 4'b0011,
                4'b1011, 4'b1011, 4'b1011, 4'b1111, 4'b1011, 4'b0000, 4'b0000,
                4'b0111, 4'b0011, 4'b1000, 4'b0011};
    in_if.valid       <= 1'b0;
    in_if.tick        <= 1'b0;
    in_if.zero_cross  <= 1'b0;
    in_if.up_button   <= 1'b1;
    in_if.down_button <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 25; i++) begin
      send_word(opening[i][3], opening[i][2], opening[i][1], opening[i][0]);
    end
    in_if.valid <= 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      load_setting(phase);
      run_traffic(200);
      in_if.valid <= 1'b0;
    end
    wait_drained();
    $display("Summary: %0d words under %0d register settings, %0d results checked, %0d fired.",
             words_sent, settings_used + 1, checked, fired);
    $display("Summary: elapsed time saturated %0d times, speed levels seen %b.",
             saturated, levels_seen);
    if (mismatches == 0 && drain_failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
design/tpasc_pkg.sv
design/tpasc_in_if.sv
design/tpasc_out_if.sv
design/triac_phase_angle_speed_control_unit.sv
dv/tpasc_motor_checker.sv
dv/tb_triac_phase_angle_speed_control_unit.sv
